// ===== rtl/pfe_pkg.sv =====
// Shared types and constants of the streaming Playfair encryptor.
// No dependencies; imported by every module of the block except pfe_fifo.
`default_nettype none

package pfe_pkg;

  localparam int SQ       = 5;
  localparam int CODE_W   = 5;
  localparam int ROW_W    = SQ * CODE_W;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 3;
  localparam int POS_W    = 3;

  localparam logic [CODE_W-1:0] LETTER_X = 5'd23;
  localparam logic [CHAR_W-1:0] ASCII_UA = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_UZ = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LA = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LZ = 8'd122;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW4 = 3'd4;

  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [SQ-1:0] square_t;

  localparam square_t SQUARE_RESET = {25'd1689702, 25'd17837208, 25'd24860464,
                                      25'd16201354, 25'd9706668};

  // One command from front to back: a pair to encipher or an end marker
  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              last;
    logic              marker;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [CODE_W-1:0] letter;
    logic              final_result;
    logic              no_letter;
    logic              bad_letter;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_fifo.sv =====
// Generic synchronous queue with push/full and pop/empty sides.
// No package dependencies; used for the command and result queues.
`default_nettype none

module pfe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

endmodule

`default_nettype wire

// ===== rtl/pfe_front.sv =====
// Front part: classifies text bytes, inserts X, pairs letters into commands.
// Depends on pfe_pkg; feeds the command queue.
`default_nettype none

module pfe_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [pfe_pkg::CHAR_W-1:0] char_code,
  input  wire logic                       end_of_text,
  output logic                            full,
  output pfe_pkg::cmd_t                   cmd,
  output logic                            cmd_push,
  input  wire logic                       cmd_full
);
  import pfe_pkg::*;

  logic              pend_v;
  logic [CODE_W-1:0] pend_l;
  logic              prev_v;
  logic [CODE_W-1:0] prev_l;
  logic              spare_v;
  cmd_t              spare;

  logic              accept;
  logic              is_letter;
  logic [CODE_W-1:0] letter;
  logic              dup;
  logic              pv;
  logic [CODE_W-1:0] pl;
  logic              c0_v;
  logic              c1_v;
  cmd_t              c0;
  cmd_t              c1;

  assign full   = spare_v || cmd_full;
  assign accept = push && !full;

  always_comb begin
    is_letter = 1'b0;
    letter    = '0;
    if (char_code inside {[ASCII_UA:ASCII_UZ]}) begin
      is_letter = 1'b1;
      letter    = CODE_W'(char_code - ASCII_UA);
    end else if (char_code inside {[ASCII_LA:ASCII_LZ]}) begin
      is_letter = 1'b1;
      letter    = CODE_W'(char_code - ASCII_LA);
    end
  end

  assign dup = is_letter && prev_v && (prev_l == letter);

  // Walk the letters of this byte; at most two pairs close.
  always_comb begin
    pv   = pend_v;
    pl   = pend_l;
    c0_v = 1'b0;
    c1_v = 1'b0;
    c0   = '0;
    c1   = '0;
    if (dup) begin
      if (pv) begin
        c0_v      = 1'b1;
        c0.first  = pl;
        c0.second = LETTER_X;
        pv        = 1'b0;
      end else begin
        pv = 1'b1;
        pl = LETTER_X;
      end
    end
    if (is_letter) begin
      if (pv) begin
        if (c0_v) begin
          c1_v      = 1'b1;
          c1.first  = pl;
          c1.second = letter;
        end else begin
          c0_v      = 1'b1;
          c0.first  = pl;
          c0.second = letter;
        end
        pv = 1'b0;
      end else begin
        pv = 1'b1;
        pl = letter;
      end
    end
    if (end_of_text) begin
      if (pv) begin
        if (c0_v) begin
          c1_v      = 1'b1;
          c1.first  = pl;
          c1.second = LETTER_X;
        end else begin
          c0_v      = 1'b1;
          c0.first  = pl;
          c0.second = LETTER_X;
        end
        pv = 1'b0;
      end
      if (!c0_v) begin
        c0_v      = 1'b1;
        c0.marker = 1'b1;
      end
      if (c1_v) begin
        c1.last = 1'b1;
      end else begin
        c0.last = 1'b1;
      end
    end
  end

  // Spare slot drains first; input is held off while it is busy.
  assign cmd      = spare_v ? spare : c0;
  assign cmd_push = spare_v ? !cmd_full : (accept && c0_v);

  always_ff @(posedge clk) begin
    if (accept && c1_v) begin
      spare <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v  <= 1'b0;
      pend_l  <= '0;
      prev_v  <= 1'b0;
      prev_l  <= '0;
      spare_v <= 1'b0;
    end else begin
      if (accept) begin
        pend_v  <= pv;
        pend_l  <= pl;
        prev_v  <= end_of_text ? 1'b0 : (prev_v || is_letter);
        if (is_letter) begin
          prev_l <= letter;
        end
        spare_v <= c1_v;
      end else if (spare_v && !cmd_full) begin
        spare_v <= 1'b0;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (!pend_v && !prev_v))
    else $error("message state not cleared after final byte");

  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    (spare_v && !cmd_full) |=> !spare_v)
    else $error("spare command not drained");

endmodule

`default_nettype wire

// ===== rtl/pfe_back.sv =====
// Back part: locates a pair in the square and emits the two cipher letters.
// Depends on pfe_pkg; reads the command queue, writes the result queue.
`default_nettype none

module pfe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pfe_pkg::square_t square,
  input  wire pfe_pkg::cmd_t    cmd,
  input  wire logic             cmd_empty,
  output logic                  cmd_pop,
  output pfe_pkg::result_t      res,
  output logic                  res_push,
  input  wire logic             res_full
);
  import pfe_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  function automatic loc_t locate(square_t sq, logic [CODE_W-1:0] code);
    loc_t l;
    l = '0;
    // Scan backward so the first matching cell wins.
    for (int r = SQ - 1; r >= 0; r--) begin
      for (int c = SQ - 1; c >= 0; c--) begin
        if (sq[r][c*CODE_W +: CODE_W] == code) begin
          l.found = 1'b1;
          l.row   = POS_W'(r);
          l.col   = POS_W'(c);
        end
      end
    end
    return l;
  endfunction

  function automatic logic [CODE_W-1:0] cell_at(square_t sq, logic [POS_W-1:0] r,
                                                logic [POS_W-1:0] c);
    row_t shifted;
    shifted = sq[r] >> (CODE_W * c);
    return shifted[CODE_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] wrap_inc(logic [POS_W-1:0] p);
    return (p == POS_W'(SQ - 1)) ? '0 : p + 1'b1;
  endfunction

  logic    hold_v;
  result_t hold;
  loc_t    la;
  loc_t    lb;
  result_t r0;
  result_t r1;
  logic    take;

  assign la = locate(square, cmd.first);
  assign lb = locate(square, cmd.second);

  always_comb begin
    r0 = '0;
    r1 = '0;
    if (cmd.marker) begin
      r0.no_letter    = 1'b1;
      r0.final_result = 1'b1;
    end else if (!la.found || !lb.found) begin
      r0.bad_letter = 1'b1;
      r1.bad_letter = 1'b1;
    end else if (la.row == lb.row) begin
      r0.letter = cell_at(square, la.row, wrap_inc(la.col));
      r1.letter = cell_at(square, lb.row, wrap_inc(lb.col));
    end else if (la.col == lb.col) begin
      r0.letter = cell_at(square, wrap_inc(la.row), la.col);
      r1.letter = cell_at(square, wrap_inc(lb.row), lb.col);
    end else begin
      r0.letter = cell_at(square, la.row, lb.col);
      r1.letter = cell_at(square, lb.row, la.col);
    end
    if (!cmd.marker) begin
      r1.final_result = cmd.last;
    end
  end

  // First letter goes out on take; second waits in the hold slot until the result queue has room.
  assign take     = !cmd_empty && !hold_v && !res_full;
  assign cmd_pop  = take;
  assign res_push = hold_v ? !res_full : take;
  assign res      = hold_v ? hold : r0;

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (hold_v) begin
      if (!res_full) begin
        hold_v <= 1'b0;
      end
    end else if (take && !cmd.marker) begin
      hold_v <= 1'b1;
    end
  end

  a_pair_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !cmd.marker) |=> hold_v)
    else $error("second letter of pair not held");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.marker) |=> !hold_v)
    else $error("end marker produced a second result");

endmodule

`default_nettype wire

// ===== rtl/playfair_stream_encrypt.sv =====
// Top level of the streaming Playfair encryptor: square registers, front,
// command queue, back and result queue. Depends on pfe_pkg and all pfe_* modules.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+-------------------------------------------
//   text in  | push / full         | char_code, end_of_text
//   cipher   | pop / empty         | cipher_letter, final_result, no_letter,
//            |                     | bad_letter
//   config   | write_en            | write_index, write_data (square rows 0..4)
//
// Flow: the front takes one byte per cycle while full is low; a byte that closes
// two pairs holds full high while its second command enters the queue.
// The back emits one letter per cycle while the result queue has room and takes
// no new pair until its hold slot drains; its single write port sets the rate.
// Reset: rst is synchronous, clears message state and both queues, and loads
// the default square. Stalls: the command and result queues let the front keep
// taking bytes while results wait on pop, and let the back drain while full.
`default_nettype none

module playfair_stream_encrypt #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [pfe_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                        end_of_text,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [pfe_pkg::CODE_W-1:0]       cipher_letter,
  output logic                             final_result,
  output logic                             no_letter,
  output logic                             bad_letter,
  input  wire logic                        write_en,
  input  wire logic [pfe_pkg::IDX_W-1:0]   write_index,
  input  wire logic [pfe_pkg::ROW_W-1:0]   write_data
);
  import pfe_pkg::*;

  square_t square;
  cmd_t    front_cmd;
  logic    front_push;
  logic    cq_full;
  cmd_t    back_cmd;
  logic    cq_empty;
  logic    cq_pop;
  result_t back_res;
  logic    back_push;
  logic    rq_full;
  result_t out_res;

  // Square rows; indexes past the last row are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      square <= SQUARE_RESET;
    end else if (write_en && (write_index inside {[REG_ROW0:REG_ROW4]})) begin
      square[write_index] <= write_data;
    end
  end

  pfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .full        (full),
    .cmd         (front_cmd),
    .cmd_push    (front_push),
    .cmd_full    (cq_full)
  );

  pfe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (back_cmd),
    .empty     (cq_empty)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .square    (square),
    .cmd       (back_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (cq_pop),
    .res       (back_res),
    .res_push  (back_push),
    .res_full  (rq_full)
  );

  pfe_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (back_push),
    .push_data (back_res),
    .full      (rq_full),
    .pop       (pop),
    .pop_data  (out_res),
    .empty     (empty)
  );

  assign cipher_letter = out_res.letter;
  assign final_result  = out_res.final_result;
  assign no_letter     = out_res.no_letter;
  assign bad_letter    = out_res.bad_letter;

endmodule

`default_nettype wire
